// ----- design/prt_pkg.sv -----
// Package for the prescaled reload timer.
// Holds the function and register address codes and the packed item layouts.
// No dependencies.
package prt_pkg;

	localparam int unsigned FUNC_W = 2;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 16;
	localparam int unsigned IN_TDATA_W = 24;
	localparam int unsigned OUT_TDATA_W = 24;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	typedef enum logic [ADDR_W-1:0] {
		ADDR_CONTROL = 3'd0,
		ADDR_IRQ_EN  = 3'd1,
		ADDR_STATUS  = 3'd2,
		ADDR_EVENT   = 3'd3,
		ADDR_COUNTER = 3'd4,
		ADDR_PRESCALE = 3'd5,
		ADDR_RELOAD  = 3'd6
	} addr_t;

	typedef struct packed {
		logic [4:0]        pad;
		logic [DATA_W-1:0] write_data;
		logic [ADDR_W-1:0] reg_addr;
	} in_data_t;

	typedef struct packed {
		logic [4:0]        pad;
		logic              running;
		logic              irq_pending;
		logic              update_flag;
		logic [DATA_W-1:0] read_data;
	} out_data_t;

endpackage

// ----- design/prescaled_reload_timer_unit.sv -----
// Top level of the prescaled reload timer: register file, prescaler and counter.
// Depends on prt_pkg for codes and item layouts.
// Each input item is a register write, a register read, one timer tick or, for
// the unused function code, no operation, and each gives one result item with
// the read value, the update flag, the interrupt request and the enable bit as
// they stand after that item. Items pass through an input register and a result
// register, so the block takes one item per clock cycle while result items are
// taken. While a result waits, the input register holds one more item and then
// the input side stalls. The state update (one increment and compare each for
// prescaler and counter) sits between the two registers.
module prescaled_reload_timer_unit #(
	parameter int unsigned COUNTER_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// Fields from bit 0: reg_addr (3), write_data (16), zero fill (5).
	input  logic [prt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// Fields from bit 0: func (2).
	input  logic [prt_pkg::FUNC_W-1:0]    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// Fields from bit 0: read_data (16), update_flag, irq_pending, running, zero fill (5).
	output logic [prt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int unsigned CW = COUNTER_WIDTH;
	localparam int unsigned DW = prt_pkg::DATA_W;

	logic                valid_s1;
	prt_pkg::func_t      func_s1;
	prt_pkg::in_data_t   data_s1;
	logic                m_valid_q;
	prt_pkg::out_data_t  result_q;
	logic                advance;

	logic          enable_q, one_pulse_q, irq_en_q, pending_q;
	logic [CW-1:0] count_q, reload_q;
	logic [DW-1:0] pre_count_q, pre_written_q, pre_active_q;

	logic          enable_d, one_pulse_d, irq_en_d, pending_d;
	logic [CW-1:0] count_d, reload_d;
	logic [DW-1:0] pre_count_d, pre_written_d, pre_active_d;
	logic [DW-1:0] rd_data;
	prt_pkg::addr_t addr;
	logic [DW-1:0] wdata;

	assign advance = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = result_q;
	assign addr = prt_pkg::addr_t'(data_s1.reg_addr);
	assign wdata = data_s1.write_data;

	always_comb begin
		enable_d = enable_q;
		one_pulse_d = one_pulse_q;
		irq_en_d = irq_en_q;
		pending_d = pending_q;
		count_d = count_q;
		reload_d = reload_q;
		pre_count_d = pre_count_q;
		pre_written_d = pre_written_q;
		pre_active_d = pre_active_q;
		rd_data = '0;
		case (func_s1)
			prt_pkg::FUNC_WRITE: begin
				case (addr)
					prt_pkg::ADDR_CONTROL: begin
						enable_d = wdata[0];
						one_pulse_d = wdata[1];
					end
					prt_pkg::ADDR_IRQ_EN: irq_en_d = wdata[0];
					prt_pkg::ADDR_STATUS: pending_d = pending_q & wdata[0];
					prt_pkg::ADDR_EVENT: begin
						if (wdata[0]) begin
							count_d = '0;
							pre_count_d = '0;
							pre_active_d = pre_written_q;
							pending_d = 1'b1;
						end
					end
					prt_pkg::ADDR_COUNTER: count_d = CW'(wdata);
					prt_pkg::ADDR_PRESCALE: pre_written_d = wdata;
					prt_pkg::ADDR_RELOAD: reload_d = CW'(wdata);
					default: ;
				endcase
			end
			prt_pkg::FUNC_READ: begin
				case (addr)
					prt_pkg::ADDR_CONTROL: rd_data = {{(DW-2){1'b0}}, one_pulse_q, enable_q};
					prt_pkg::ADDR_IRQ_EN: rd_data = {{(DW-1){1'b0}}, irq_en_q};
					prt_pkg::ADDR_STATUS: rd_data = {{(DW-1){1'b0}}, pending_q};
					prt_pkg::ADDR_COUNTER: rd_data = DW'(count_q);
					prt_pkg::ADDR_PRESCALE: rd_data = pre_written_q;
					prt_pkg::ADDR_RELOAD: rd_data = DW'(reload_q);
					default: rd_data = '0;
				endcase
			end
			prt_pkg::FUNC_TICK: begin
				if (enable_q) begin
					if (pre_count_q >= pre_active_q) begin
						pre_count_d = '0;
						if (count_q >= reload_q) begin
							count_d = '0;
							pre_active_d = pre_written_q;
							pending_d = 1'b1;
							if (one_pulse_q) begin
								enable_d = 1'b0;
							end
						end else begin
							count_d = count_q + CW'(1);
						end
					end else begin
						pre_count_d = pre_count_q + DW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_valid_q <= 1'b0;
			enable_q <= 1'b0;
			one_pulse_q <= 1'b0;
			irq_en_q <= 1'b0;
			pending_q <= 1'b0;
			count_q <= '0;
			reload_q <= '1;
			pre_count_q <= '0;
			pre_written_q <= '0;
			pre_active_q <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (advance) begin
				enable_q <= enable_d;
				one_pulse_q <= one_pulse_d;
				irq_en_q <= irq_en_d;
				pending_q <= pending_d;
				count_q <= count_d;
				reload_q <= reload_d;
				pre_count_q <= pre_count_d;
				pre_written_q <= pre_written_d;
				pre_active_q <= pre_active_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			func_s1 <= prt_pkg::func_t'(s_axis_tuser);
			data_s1 <= prt_pkg::in_data_t'(s_axis_tdata);
		end
		if (advance) begin
			result_q.pad <= '0;
			result_q.read_data <= rd_data;
			result_q.update_flag <= pending_d;
			result_q.irq_pending <= pending_d & irq_en_d;
			result_q.running <= enable_d;
		end
	end

`ifndef ASSERT_OFF
	a_prescale_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pre_count_q <= pre_active_q)
		else $error("prescale count above active prescaler");

	a_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (result_q.running == enable_q) && (result_q.update_flag == pending_q))
		else $error("result item does not match timer state");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (m_valid_q && !m_axis_tready))
		else $error("input stage stalled without a waiting result");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(count_q) && $stable(pre_count_q) && $stable(pending_q))
		else $error("timer state changed without an item");
`endif

endmodule

// ----- tb/prescaled_reload_timer_checker.sv -----
// Checker for the prescaled reload timer: watches both item streams and
// predicts every result item from its own copy of the timer registers.
// Depends on prt_pkg for the function and address codes and the item layouts.
`timescale 1ns / 100ps

module prescaled_reload_timer_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [prt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [prt_pkg::FUNC_W-1:0]      s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [prt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output int                              errors,
	output int                              outstanding,
	output int                              checked,
	output int                              flagged
);

	typedef logic [prt_pkg::DATA_W-1:0] word_t;

	logic  enable_bit;
	logic  one_pulse;
	logic  irq_enable;
	logic  update_seen;
	word_t count_q;
	word_t prescale_q;
	word_t prescale_buf;
	word_t prescale_live;
	word_t reload_q;

	prt_pkg::out_data_t timer_results[$];
	prt_pkg::out_data_t want;
	prt_pkg::out_data_t seen;
	prt_pkg::in_data_t  req;
	int                 n_in;
	int                 n_out;

	assign outstanding = n_in - n_out;
	assign checked = n_out;

	function automatic void load_update();
		prescale_live = prescale_buf;
		update_seen = 1'b1;
	endfunction

	// Applies one item to the timer registers and returns the result it gives.
	function automatic prt_pkg::out_data_t timer_step(logic [prt_pkg::FUNC_W-1:0] f,
			logic [prt_pkg::ADDR_W-1:0] a, word_t d);
		prt_pkg::out_data_t r;
		word_t rd;
		rd = '0;
		case (f)
			prt_pkg::FUNC_WRITE: begin
				case (a)
					prt_pkg::ADDR_CONTROL: begin
						enable_bit = d[0];
						one_pulse = d[1];
					end
					prt_pkg::ADDR_IRQ_EN: irq_enable = d[0];
					prt_pkg::ADDR_STATUS: update_seen = update_seen & d[0];
					prt_pkg::ADDR_EVENT: begin
						if (d[0]) begin
							count_q = '0;
							prescale_q = '0;
							load_update();
						end
					end
					prt_pkg::ADDR_COUNTER: count_q = d;
					prt_pkg::ADDR_PRESCALE: prescale_buf = d;
					prt_pkg::ADDR_RELOAD: reload_q = d;
					default: ;
				endcase
			end
			prt_pkg::FUNC_READ: begin
				case (a)
					prt_pkg::ADDR_CONTROL: rd = {14'd0, one_pulse, enable_bit};
					prt_pkg::ADDR_IRQ_EN: rd = {15'd0, irq_enable};
					prt_pkg::ADDR_STATUS: rd = {15'd0, update_seen};
					prt_pkg::ADDR_COUNTER: rd = count_q;
					prt_pkg::ADDR_PRESCALE: rd = prescale_buf;
					prt_pkg::ADDR_RELOAD: rd = reload_q;
					default: rd = '0;
				endcase
			end
			prt_pkg::FUNC_TICK: begin
				if (enable_bit) begin
					if (prescale_q >= prescale_live) begin
						prescale_q = '0;
						if (count_q >= reload_q) begin
							count_q = '0;
							load_update();
							if (one_pulse) begin
								enable_bit = 1'b0;
							end
						end else begin
							count_q = count_q + word_t'(1);
						end
					end else begin
						prescale_q = prescale_q + word_t'(1);
					end
				end
			end
			default: ;
		endcase
		r = '0;
		r.read_data = rd;
		r.update_flag = update_seen;
		r.irq_pending = update_seen & irq_enable;
		r.running = enable_bit;
		return r;
	endfunction

	function automatic void check_field(string name, word_t exp_val, word_t act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_bit = 1'b0;
			one_pulse = 1'b0;
			irq_enable = 1'b0;
			update_seen = 1'b0;
			count_q = '0;
			prescale_q = '0;
			prescale_buf = '0;
			prescale_live = '0;
			reload_q = '1;
			timer_results.delete();
			errors = 0;
			n_in <= 0;
			n_out <= 0;
			flagged <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen = m_axis_tdata;
				if (timer_results.size() == 0) begin
					$error("result item with none expected: tdata %h", m_axis_tdata);
					errors++;
				end else begin
					want = timer_results.pop_front();
					check_field("read_data", want.read_data, seen.read_data);
					check_field("update_flag", word_t'(want.update_flag),
						word_t'(seen.update_flag));
					check_field("irq_pending", word_t'(want.irq_pending),
						word_t'(seen.irq_pending));
					check_field("running", word_t'(want.running), word_t'(seen.running));
				end
				n_out <= n_out + 1;
				if (seen.update_flag === 1'b1) begin
					flagged <= flagged + 1;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req = s_axis_tdata;
				timer_results.push_back(timer_step(s_axis_tuser, req.reg_addr,
					req.write_data));
				n_in <= n_in + 1;
			end
		end
	end

endmodule

// ----- tb/prescaled_reload_timer_unit_test.sv -----
// Testbench top for the prescaled reload timer: clock, reset, item stimulus
// under several idle and stall phases, watchdog and verdict.
// Depends on prt_pkg, prescaled_reload_timer_unit and prescaled_reload_timer_checker.
`timescale 1ns / 100ps

module prescaled_reload_timer_unit_test;

	typedef logic [prt_pkg::DATA_W-1:0] word_t;
	typedef logic [prt_pkg::ADDR_W-1:0] addr_bits_t;

	localparam logic [prt_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
	localparam addr_bits_t ADDR_UNUSED = 3'd7;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int QUIET_LIMIT = 2000;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [prt_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic [prt_pkg::FUNC_W-1:0]      s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [prt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	int errors;
	int outstanding;
	int checked;
	int flagged;
	int items_sent;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	int idle_plan[4] = '{0, 59, 0, 16};
	int stall_plan[4] = '{0, 0, 59, 16};

	prescaled_reload_timer_unit #(.COUNTER_WIDTH(16)) dut (.*);

	prescaled_reload_timer_checker checker_i (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles.", QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [prt_pkg::FUNC_W-1:0] f, input addr_bits_t a,
			input word_t d);
		prt_pkg::in_data_t item;
		item = '0;
		item.reg_addr = a;
		item.write_data = d;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= item;
		s_axis_tuser <= f;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic send_random();
		int pick;
		logic [prt_pkg::FUNC_W-1:0] f;
		addr_bits_t a;
		word_t d;
		pick = $urandom_range(0, 99);
		a = addr_bits_t'($urandom_range(0, 7));
		d = word_t'($urandom);
		if (pick < 50) begin
			f = prt_pkg::FUNC_TICK;
		end else if (pick < 68) begin
			f = prt_pkg::FUNC_READ;
		end else if (pick < 96) begin
			f = prt_pkg::FUNC_WRITE;
			// Short periods and a set enable bit most of the time, so that the counter wraps often.
			case (a)
				prt_pkg::ADDR_CONTROL: if ($urandom_range(0, 9) < 8) d[0] = 1'b1;
				prt_pkg::ADDR_PRESCALE: begin
					if ($urandom_range(0, 9) < 9) d = word_t'($urandom_range(0, 3));
				end
				prt_pkg::ADDR_RELOAD, prt_pkg::ADDR_COUNTER: begin
					if ($urandom_range(0, 9) < 9) d = word_t'($urandom_range(0, 12));
				end
				default: ;
			endcase
		end else begin
			f = FUNC_NONE;
		end
		send_item(f, a, d);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = prt_pkg::FUNC_TICK;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		items_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(prt_pkg::FUNC_READ, prt_pkg::ADDR_RELOAD, 16'h0000);
		send_item(prt_pkg::FUNC_READ, prt_pkg::ADDR_CONTROL, 16'hFFFF);
		send_item(prt_pkg::FUNC_WRITE, prt_pkg::ADDR_PRESCALE, 16'h0001);
		send_item(prt_pkg::FUNC_WRITE, prt_pkg::ADDR_RELOAD, 16'h0002);
		send_item(prt_pkg::FUNC_WRITE, prt_pkg::ADDR_IRQ_EN, 16'hFFFF);
		send_item(prt_pkg::FUNC_WRITE, prt_pkg::ADDR_EVENT, 16'h0001);
		send_item(prt_pkg::FUNC_WRITE, prt_pkg::ADDR_STATUS, 16'hFFFE);
		send_item(prt_pkg::FUNC_WRITE, prt_pkg::ADDR_CONTROL, 16'h0001);
		repeat (6) send_item(prt_pkg::FUNC_TICK, prt_pkg::ADDR_CONTROL, 16'h0000);
		send_item(prt_pkg::FUNC_WRITE, prt_pkg::ADDR_COUNTER, 16'hFFFF);
		repeat (2) send_item(prt_pkg::FUNC_TICK, prt_pkg::ADDR_RELOAD, 16'hFFFF);
		send_item(prt_pkg::FUNC_WRITE, prt_pkg::ADDR_RELOAD, 16'h0000);
		send_item(prt_pkg::FUNC_WRITE, prt_pkg::ADDR_CONTROL, 16'h0003);
		repeat (3) send_item(prt_pkg::FUNC_TICK, prt_pkg::ADDR_STATUS, 16'h0000);
		send_item(prt_pkg::FUNC_WRITE, prt_pkg::ADDR_CONTROL, 16'h0003);
		send_item(prt_pkg::FUNC_WRITE, prt_pkg::ADDR_EVENT, 16'hFFFF);
		send_item(prt_pkg::FUNC_WRITE, ADDR_UNUSED, 16'hFFFF);
		send_item(prt_pkg::FUNC_READ, ADDR_UNUSED, 16'h0000);
		send_item(FUNC_NONE, prt_pkg::ADDR_COUNTER, 16'hFFFF);
		send_item(prt_pkg::FUNC_READ, prt_pkg::ADDR_STATUS, 16'h0000);
		send_item(prt_pkg::FUNC_READ, prt_pkg::ADDR_COUNTER, 16'h0000);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_plan[ph];
			recv_stall_pct = stall_plan[ph];
			repeat (ITEMS_PER_PHASE) send_random();
			drain();
		end

		repeat (4) @(posedge clk);
		$display("Sent %0d items and checked %0d results: register, tick, update and",
			items_sent, checked);
		$display("one-pulse cases, then random traffic under four idle/stall phases; %0d %s",
			flagged, "results had the update flag set.");
		if (errors == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
